/* sv/bc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants for the binomial coefficient block
// Job descriptor passed from the front end to the back end, sequencer
// states and datapath widths.
// ----------------------------------------------------------------------------
package bc_pkg;

   localparam int ARG_W   = 16;                  // n and k
   localparam int MULT_W  = ARG_W + 1;           // n-k+d
   localparam int COEF_W  = 64;                  // result width
   localparam int HALF_W  = COEF_W / 2;          // multiplier operand split
   localparam int DIV_BITS   = 8;                // quotient bits per cycle
   localparam int PROD_W     = 88;               // padded product width
   localparam int DIV_CYCLES = PROD_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [COEF_W-1:0] SAT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFE;

   typedef enum logic [1:0] {
      JOB_ZERO,
      JOB_ONE,
      JOB_LOOP
   } bc_kind_type;

   typedef struct packed {
      bc_kind_type      kind;
      logic [ARG_W-1:0] base_j;   // n - k after folding k
      logic [ARG_W-1:0] steps_k;  // folded k, number of steps
   } bc_job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIVIDE,
      ST_CHECK,
      ST_HOLD
   } bc_state_type;

endpackage

/* sv/bc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_front: request classifier
// Sorts each request into a trivial case or a loop job and folds k to
// min(k, n-k).
// ----------------------------------------------------------------------------
module bc_front (
   input  logic [15:0]        req_count_n,
   input  logic [15:0]        req_choose_k,
   output bc_pkg::bc_job_type job
);
   import bc_pkg::*;

   logic [ARG_W-1:0] rest;
   logic [ARG_W-1:0] fold_k;

   assign rest   = req_count_n - req_choose_k;
   assign fold_k = (rest < req_choose_k) ? rest : req_choose_k;

   always_comb begin
      job.base_j  = req_count_n - fold_k;
      job.steps_k = fold_k;
      if (req_choose_k > req_count_n) begin
         job.kind = JOB_ZERO;
      end else if (req_choose_k == '0 || req_choose_k == req_count_n) begin
         job.kind = JOB_ONE;
      end else begin
         job.kind = JOB_LOOP;
      end
   end

endmodule

/* sv/bc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_queue: job queue
// Small FIFO of job descriptors between the front end and the back end.
// ----------------------------------------------------------------------------
module bc_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bc_pkg::bc_job_type push_job,
   output logic               full,
   output logic               head_valid,
   output bc_pkg::bc_job_type head_job,
   input  logic               pop
);
   import bc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   bc_job_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && !full;
   assign pop_fire   = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

/* sv/bc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_back: multiply-divide sequencer
// Runs r = r * (j + d) / d for d = 1 .. k with a split 32x17 multiplier and
// an 8-bit-per-cycle restoring divider; holds the result in an output
// register.
// ----------------------------------------------------------------------------
module bc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  bc_pkg::bc_job_type job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_coefficient,
   output logic               rsp_saturated
);
   import bc_pkg::*;

   bc_state_type          state_ff, state_in;
   logic [COEF_W-1:0]     r_ff, r_in;
   logic                  sat_ff, sat_in;
   logic [ARG_W-1:0]      j_ff, j_in;
   logic [ARG_W-1:0]      k_ff, k_in;
   logic [ARG_W-1:0]      d_ff, d_in;
   logic [PROD_W-1:0]     p_ff, p_in;
   logic [ARG_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COEF_W-1:0]     out_coef_ff, out_coef_in;
   logic                  out_sat_ff, out_sat_in;

   logic [MULT_W-1:0]          mult;
   logic [HALF_W+MULT_W-1:0]   lo_prod;
   logic [HALF_W+MULT_W-1:0]   hi_prod;
   logic [HALF_W+MULT_W-1:0]   hi_sum;
   logic [ARG_W-1:0]           div_rem;
   logic [DIV_BITS-1:0]        div_q;
   logic                       big;

   assign mult    = MULT_W'(j_ff) + MULT_W'(d_ff);
   assign lo_prod = r_ff[HALF_W-1:0] * mult;
   assign hi_prod = r_ff[COEF_W-1:HALF_W] * mult;
   assign hi_sum  = hi_prod + (HALF_W+MULT_W)'(p_ff[HALF_W+MULT_W-1:HALF_W]);
   assign big     = |p_ff[PROD_W-1:COEF_W];

   // eight restoring division steps on the top byte of the dividend
   always_comb begin
      logic [ARG_W:0] trial;
      div_rem = rem_ff;
      div_q   = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {div_rem, p_ff[PROD_W-1-i]};
         if (trial >= {1'b0, d_ff}) begin
            trial = trial - {1'b0, d_ff};
            div_q[DIV_BITS-1-i] = 1'b1;
         end
         div_rem = trial[ARG_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      sat_in       = sat_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_coef_in  = out_coef_ff;
      out_sat_in   = out_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               sat_in  = 1'b0;
               j_in    = job.base_j;
               k_in    = job.steps_k;
               d_in    = ARG_W'(1);
               case (job.kind)
                  JOB_ZERO: begin
                     r_in     = '0;
                     state_in = ST_HOLD;
                  end
                  JOB_ONE: begin
                     r_in     = COEF_W'(1);
                     state_in = ST_HOLD;
                  end
                  JOB_LOOP: begin
                     r_in     = COEF_W'(1);
                     state_in = ST_MUL_LO;
                  end
                  default: begin
                     r_in     = '0;
                     state_in = ST_HOLD;
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            p_in     = PROD_W'(lo_prod);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            p_in     = {(PROD_W-COEF_W-MULT_W)'(0), hi_sum, p_ff[HALF_W-1:0]};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            p_in   = {p_ff[PROD_W-DIV_BITS-1:0], div_q};
            rem_in = div_rem;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (big || p_ff[COEF_W-1:0] >= SAT_LIMIT) begin
               r_in     = SAT_LIMIT;
               sat_in   = 1'b1;
               state_in = ST_HOLD;
            end else begin
               r_in = p_ff[COEF_W-1:0];
               if (d_ff == k_ff) begin
                  state_in = ST_HOLD;
               end else begin
                  d_in     = d_ff + ARG_W'(1);
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_HOLD: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_coef_in  = r_ff;
               out_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      sat_ff      <= sat_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      out_coef_ff <= out_coef_in;
      out_sat_ff  <= out_sat_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_coefficient = out_coef_ff;
   assign rsp_saturated   = out_sat_ff;

`ifndef SYNTHESIS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < d_ff))
      else $error("division remainder not below divisor");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (d_ff != '0 && d_ff <= k_ff))
      else $error("step counter out of range");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sat_ff) |-> (out_coef_ff == SAT_LIMIT))
      else $error("saturated result without limit value");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (job_valid && state_ff == ST_IDLE))
      else $error("job taken while busy or queue empty");
`endif

endmodule

/* sv/binomial_coefficient_saturating_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_coefficient_saturating_top: saturating binomial coefficient
// Returns C(n,k) for 16-bit n and k as a 64-bit value, saturating to
// 2^64-2 with a flag.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat fields                        handshake
//   -------   ---   --------------------------------   ----------------------
//   req       in    req_count_n, req_choose_k          req_valid / req_stall
//   rsp       out   rsp_coefficient, rsp_saturated     rsp_valid / rsp_stall
//
// Back end: k > n, k == 0 and k == n pass from idle straight to the hold
//   state. Other beats run one multiply-divide step per d (the low and high
//   multiply states, the divide state, a check), over min(k, n-k) steps or
//   fewer when the value saturates early; at most 34 steps.
// The sequencer in bc_back sets the rate: one beat is worked at a time.
// Reset clears the queue, the sequencer and the output valid.
// req_stall rises only when the job queue is full; a stalled rsp beat holds
//   in the output register while the back end finishes the next job.
//
module binomial_coefficient_saturating_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_count_n,
   input  logic [15:0] req_choose_k,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_coefficient,
   output logic        rsp_saturated
);
   import bc_pkg::*;

   bc_job_type front_job;   // classified request
   bc_job_type head_job;    // oldest queued job
   logic       queue_full;
   logic       head_valid;
   logic       job_pop;

   // classify each beat as it arrives
   bc_front u_front (
      .req_count_n  (req_count_n),
      .req_choose_k (req_choose_k),
      .job          (front_job)
   );

   // decouple intake from the long-running sequencer
   bc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_job   (front_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop)
   );

   // stall intake only when no queue slot is free
   assign req_stall = queue_full;

   // run the multiply-divide recurrence and hold the result
   bc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (head_valid),
      .job             (head_job),
      .job_pop         (job_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
